/* rtl/lgf_pkg.sv */
// Shared constants, tables and control types of the lattice gamma factor engine.
package lgf_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;

   // floor(2^64 / (2*pi)) split into 32-bit halves.
   localparam logic [31:0] INV_2PI_HI = 32'h28BE60DB;
   localparam logic [31:0] INV_2PI_LO = 32'h9391054A;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [31:0]        EIGHTH_TURN = 32'h20000000;

   typedef struct packed {
      logic       take;
      logic       idx_clr;
      logic       idx_inc;
      logic       mem_rd;
      logic       ang_clr;
      logic       mul_go;
      logic       mul_use;
      logic [1:0] comp;
      logic [2:0] part;
      logic       cor_init;
      logic       cor_step;
      logic [4:0] cor_k;
      logic       acc_go;
      logic       sum_clr;
      logic       div_load;
      logic       div_step;
      logic       out_load;
   } lgf_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic last_nbr;
   } lgf_sts_type;

   // atan(2^-k) in units of 2^-32 turn.
   function automatic logic [31:0] atan_turns(input logic [4:0] k);
      logic [31:0] v;
      case (k)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933405;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335086;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41721;
         5'd15: v = 32'd20860;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2607;
         5'd19: v = 32'd1303;
         5'd20: v = 32'd651;
         5'd21: v = 32'd325;
         5'd22: v = 32'd162;
         5'd23: v = 32'd81;
         5'd24: v = 32'd40;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd2;
         5'd29: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/lattice_gamma_factor.sv */
// Top level of the lattice gamma factor engine.
// Keeps up to MAX_NEIGHBORS displacement vectors (kind 1 appends, kind 0 clears) and,
// for a kind 2 item carrying wavevector K, returns the mean of exp(-i K.r) over the
// stored vectors in Q2.30 with a status (0 ok, 1 empty list, 2 appends were dropped).
// Clear and append items are done as they are taken. A query walks the neighbors one at a
// time: each gets one store read, fifteen passes through the shared 33x33 multiplier for
// the three phase products and their turn conversion, and the iterative CORDIC at the
// default 24 steps; a bit-serial divider then forms the mean, and an empty-list query
// skips both the walk and the divider.
// The result sits in an output register, and new items are taken while it waits.
module lattice_gamma_factor #(
   parameter int MAX_NEIGHBORS = 64,
   parameter int CORDIC_STEPS  = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // vec_x, vec_y, vec_z
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // gamma_re, gamma_im
   output logic [1:0]  rsp_tuser    // status
);

   localparam int CW    = $clog2(MAX_NEIGHBORS + 1);
   localparam int SUM_W = 34 + CW;

   lgf_pkg::lgf_cmd_type cmd;
   lgf_pkg::lgf_sts_type sts;

   lgf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .SUM_W        (SUM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lgf_dp #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .SUM_W         (SUM_W)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_cmd  (req_tuser),
      .req_vec  (req_tdata),
      .gamma_re (rsp_tdata[31:0]),
      .gamma_im (rsp_tdata[63:32]),
      .status   (rsp_tuser)
   );

endmodule

/* rtl/lgf_ctrl.sv */
// Sequencer of the lattice gamma factor engine.
module lgf_ctrl #(
   parameter int CORDIC_STEPS = 24,
   parameter int SUM_W        = 41
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [1:0]          req_cmd,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output lgf_pkg::lgf_cmd_type cmd,
   input  lgf_pkg::lgf_sts_type sts
);

   localparam int SW = $clog2(SUM_W + CORDIC_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_MULA, S_MULB, S_CINIT, S_CSTEP, S_ACC, S_DIVL, S_DIV, S_FIN
   } state_type;

   state_type     state_ff;
   logic          rsp_valid_ff;
   logic [1:0]    comp_ff;
   logic [2:0]    part_ff;
   logic [SW-1:0] step_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.comp  = comp_ff;
      cmd.part  = part_ff;
      cmd.cor_k = step_ff[4:0];
      case (state_ff)
         S_IDLE: begin
            cmd.take = req_tvalid;
            if (req_tvalid && req_cmd == lgf_pkg::CMD_QUERY) begin
               cmd.idx_clr = 1'b1;
               cmd.sum_clr = 1'b1;
            end
         end
         S_RD: begin
            cmd.mem_rd  = 1'b1;
            cmd.ang_clr = 1'b1;
         end
         S_MULA:  cmd.mul_go = 1'b1;
         S_MULB:  cmd.mul_use = 1'b1;
         S_CINIT: cmd.cor_init = 1'b1;
         S_CSTEP: cmd.cor_step = 1'b1;
         S_ACC: begin
            cmd.acc_go  = 1'b1;
            cmd.idx_inc = !sts.last_nbr;
         end
         S_DIVL: cmd.div_load = 1'b1;
         S_DIV:  cmd.div_step = 1'b1;
         S_FIN:  cmd.out_load = !rsp_valid_ff || rsp_tready;
         default: cmd.take = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         comp_ff      <= '0;
         part_ff      <= '0;
         step_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_cmd == lgf_pkg::CMD_QUERY) begin
                  state_ff <= sts.cnt_zero ? S_FIN : S_RD;
               end
            end
            S_RD: begin
               comp_ff  <= '0;
               part_ff  <= '0;
               state_ff <= S_MULA;
            end
            S_MULA: state_ff <= S_MULB;
            S_MULB: begin
               if (part_ff == 3'd4) begin
                  part_ff <= '0;
                  if (comp_ff == 2'd2) begin
                     state_ff <= S_CINIT;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= S_MULA;
                  end
               end else begin
                  part_ff  <= part_ff + 3'd1;
                  state_ff <= S_MULA;
               end
            end
            S_CINIT: begin
               step_ff  <= '0;
               state_ff <= S_CSTEP;
            end
            S_CSTEP: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == SW'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: state_ff <= sts.last_nbr ? S_DIVL : S_RD;
            S_DIVL: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == SW'(SUM_W - 1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_fin_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff) else $error("result not presented after load");

   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CSTEP |-> step_ff < SW'(CORDIC_STEPS)) else $error("CORDIC step overrun");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> step_ff < SW'(SUM_W)) else $error("divider step overrun");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !cmd.take) else $error("item taken while busy");

endmodule

/* rtl/lgf_dp.sv */
// Datapath: neighbor store, phase multiplier, CORDIC, accumulators and divider.
module lgf_dp #(
   parameter int MAX_NEIGHBORS = 64,
   parameter int SUM_W         = 41
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lgf_pkg::lgf_cmd_type cmd,
   output lgf_pkg::lgf_sts_type sts,
   input  logic [1:0]           req_cmd,
   input  logic [95:0]          req_vec,
   output logic [31:0]          gamma_re,
   output logic [31:0]          gamma_im,
   output logic [1:0]           status
);

   localparam int CW = $clog2(MAX_NEIGHBORS + 1);
   localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

   logic [95:0]   mem [MAX_NEIGHBORS];
   logic [CW-1:0] count_ff;
   logic          ovf_ff;
   logic [AW-1:0] idx_ff;
   logic [95:0]   k_ff;
   logic [95:0]   rd_ff;

   logic                 append_ok;
   logic signed [32:0]   ma, mb;
   logic signed [65:0]   prod_ff;
   logic [63:0]          p_ff;
   logic [95:0]          acc_ff;
   logic [95:0]          prod_ext;
   logic [95:0]          acc_last;
   logic [31:0]          angle_ff;
   logic [31:0]          kc, rc;
   logic [31:0]          shifted;

   logic signed [33:0] x_ff, y_ff;
   logic signed [32:0] z_ff;
   logic [1:0]         quad_ff;
   logic signed [33:0] cos_v, sin_v;

   logic signed [SUM_W-1:0] sum_ff [2];
   logic [SUM_W-1:0]        quo_ff [2];
   logic [CW:0]             rem_ff [2];
   logic                    neg_ff [2];
   logic [CW:0]             rem_sh [2];
   logic                    ge     [2];
   logic [31:0]             res    [2];

   assign append_ok = count_ff < CW'(MAX_NEIGHBORS);
   assign sts.cnt_zero = (count_ff == '0);
   assign sts.last_nbr = (CW'(idx_ff) == count_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.take && req_cmd == lgf_pkg::CMD_APPEND && append_ok) begin
         mem[count_ff[AW-1:0]] <= req_vec;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (cmd.take && req_cmd == lgf_pkg::CMD_CLEAR) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
         if (cmd.take && req_cmd == lgf_pkg::CMD_APPEND) begin
            if (append_ok) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      case (cmd.comp)
         2'd0: begin kc = k_ff[31:0];  rc = rd_ff[31:0];  end
         2'd1: begin kc = k_ff[63:32]; rc = rd_ff[63:32]; end
         2'd2: begin kc = k_ff[95:64]; rc = rd_ff[95:64]; end
         default: begin kc = '0; rc = '0; end
      endcase
      // The phase product K.r, then its partial products times 1/(2*pi), high half signed.
      case (cmd.part)
         3'd0: begin ma = {kc[31], kc};             mb = {rc[31], rc}; end
         3'd1: begin ma = {1'b0, p_ff[31:0]};       mb = {1'b0, lgf_pkg::INV_2PI_LO}; end
         3'd2: begin ma = {p_ff[63], p_ff[63:32]};  mb = {1'b0, lgf_pkg::INV_2PI_LO}; end
         3'd3: begin ma = {1'b0, p_ff[31:0]};       mb = {1'b0, lgf_pkg::INV_2PI_HI}; end
         default: begin ma = {p_ff[63], p_ff[63:32]}; mb = {1'b0, lgf_pkg::INV_2PI_HI}; end
      endcase
      prod_ext = {{30{prod_ff[65]}}, prod_ff};
      acc_last = acc_ff + {prod_ext[31:0], 64'd0};
      shifted  = angle_ff + lgf_pkg::EIGHTH_TURN;
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req_cmd == lgf_pkg::CMD_QUERY) begin
         k_ff <= req_vec;
      end
      if (cmd.mul_go) begin
         prod_ff <= ma * mb;
      end
      if (cmd.ang_clr) begin
         angle_ff <= '0;
      end
      if (cmd.mul_use) begin
         case (cmd.part)
            3'd0: begin
               p_ff   <= prod_ff[63:0];
               acc_ff <= '0;
            end
            3'd1: acc_ff <= acc_ff + prod_ext;
            3'd2, 3'd3: acc_ff <= acc_ff + {prod_ext[63:0], 32'd0};
            default: angle_ff <= angle_ff + acc_last[95:64];
         endcase
      end
   end

   always_comb begin
      case (quad_ff)
         2'd0: begin cos_v = x_ff;  sin_v = y_ff;  end
         2'd1: begin cos_v = -y_ff; sin_v = x_ff;  end
         2'd2: begin cos_v = -x_ff; sin_v = -y_ff; end
         default: begin cos_v = y_ff; sin_v = -x_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.cor_init) begin
         quad_ff <= shifted[31:30];
         z_ff    <= $signed({3'b000, shifted[29:0]}) - $signed({1'b0, lgf_pkg::EIGHTH_TURN});
         x_ff    <= lgf_pkg::CORDIC_GAIN;
         y_ff    <= '0;
      end else if (cmd.cor_step) begin
         if (!z_ff[32]) begin
            x_ff <= x_ff - (y_ff >>> cmd.cor_k);
            y_ff <= y_ff + (x_ff >>> cmd.cor_k);
            z_ff <= z_ff - $signed({1'b0, lgf_pkg::atan_turns(cmd.cor_k)});
         end else begin
            x_ff <= x_ff + (y_ff >>> cmd.cor_k);
            y_ff <= y_ff - (x_ff >>> cmd.cor_k);
            z_ff <= z_ff + $signed({1'b0, lgf_pkg::atan_turns(cmd.cor_k)});
         end
      end
   end

   // Restoring division of the sum magnitudes by the neighbor count, signed result saturated to 32 bits.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem_sh[l] = {rem_ff[l][CW-1:0], quo_ff[l][SUM_W-1]};
         ge[l]     = rem_sh[l] >= {1'b0, count_ff};
         if (neg_ff[l]) begin
            res[l] = (quo_ff[l] > SUM_W'(32'h80000000)) ? 32'h80000000 : -quo_ff[l][31:0];
         end else begin
            res[l] = (quo_ff[l] > SUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo_ff[l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_clr) begin
         sum_ff[0] <= '0;
         sum_ff[1] <= '0;
      end else if (cmd.acc_go) begin
         sum_ff[0] <= sum_ff[0] + {{(SUM_W-34){cos_v[33]}}, cos_v};
         sum_ff[1] <= sum_ff[1] - {{(SUM_W-34){sin_v[33]}}, sin_v};
      end
      for (int l = 0; l < 2; l++) begin
         if (cmd.div_load) begin
            neg_ff[l] <= sum_ff[l][SUM_W-1];
            quo_ff[l] <= sum_ff[l][SUM_W-1] ? -sum_ff[l] : sum_ff[l];
            rem_ff[l] <= '0;
         end else if (cmd.div_step) begin
            rem_ff[l] <= ge[l] ? rem_sh[l] - {1'b0, count_ff} : rem_sh[l];
            quo_ff[l] <= {quo_ff[l][SUM_W-2:0], ge[l]};
         end
      end
      if (cmd.out_load) begin
         if (count_ff == '0) begin
            gamma_re <= '0;
            gamma_im <= '0;
            status   <= lgf_pkg::ST_EMPTY;
         end else begin
            gamma_re <= res[0];
            gamma_im <= res[1];
            status   <= ovf_ff ? lgf_pkg::ST_DROPPED : lgf_pkg::ST_OK;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NEIGHBORS)) else $error("neighbor count beyond capacity");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> CW'(idx_ff) < count_ff) else $error("read beyond stored neighbors");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> count_ff == CW'(MAX_NEIGHBORS)) else $error("overflow on non-full list");

endmodule

/* test/tb_lattice_gamma_factor.sv */
// Testbench of the lattice gamma factor engine: directed and random item streams checked
// against a bit-exact predictor.
module tb_lattice_gamma_factor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int NBR_DEPTH = 64;
   localparam int ROT_STEPS = 24;
   localparam int STALL_LIMIT = 50000;
   localparam logic [63:0] TURNS_PER_RAD = 64'h28BE60DB9391054A;
   localparam longint ROT_GAIN = 652032874;
   localparam longint ATAN_TBL [0:31] = '{
      536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
      41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
      10, 5, 2, 1, 0, 0};

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic [1:0]  status;
   } gamma_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // vec_x, vec_y, vec_z
   logic [1:0]  req_tuser = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // gamma_re, gamma_im
   logic [1:0]  rsp_tuser;        // status

   lattice_gamma_factor dut (.*);

   always #1 clock = ~clock;

   // Predictor state.
   logic signed [31:0] pred_x [NBR_DEPTH];
   logic signed [31:0] pred_y [NBR_DEPTH];
   logic signed [31:0] pred_z [NBR_DEPTH];
   int  pred_count = 0;
   bit  pred_dropped = 0;

   gamma_result_type gamma_queue [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  gammas_seen = 0;
   int  quiet_cycles = 0;
   int  rsp_hold = 0;
   bit  no_idle = 0;

   function automatic logic [31:0] rad_to_turns(input longint p);
      logic [127:0] prod;
      logic [31:0]  h;
      prod = {64'd0, p} * {64'd0, TURNS_PER_RAD};
      h = prod[95:64];
      if (p < 0) h = h - TURNS_PER_RAD[31:0];
      return h;
   endfunction

   task automatic rotate_turns(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] shifted;
      longint x, y, z, dx, dy;
      shifted = ang + lgf_pkg::EIGHTH_TURN;
      z = longint'(shifted[29:0]) - longint'(lgf_pkg::EIGHTH_TURN);
      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> (i & 31);
         dy = x >>> (i & 31);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TBL[i & 31];
         end else begin
            x += dx; y -= dy; z += ATAN_TBL[i & 31];
         end
      end
      case (shifted[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Updates the predictor for one accepted item and queues the gamma it causes.
   task automatic predict_gamma(input logic [1:0] cmd, input logic signed [31:0] kx,
                                input logic signed [31:0] ky, input logic signed [31:0] kz);
      longint sum_re, sum_im, c, s;
      logic [31:0] ang;
      gamma_result_type r;
      sum_re = 0;
      sum_im = 0;
      case (cmd)
         lgf_pkg::CMD_CLEAR: begin
            pred_count = 0;
            pred_dropped = 0;
         end
         lgf_pkg::CMD_APPEND: begin
            if (pred_count < NBR_DEPTH) begin
               pred_x[pred_count] = kx;
               pred_y[pred_count] = ky;
               pred_z[pred_count] = kz;
               pred_count++;
            end else begin
               pred_dropped = 1;
            end
         end
         lgf_pkg::CMD_QUERY: begin
            if (pred_count == 0) begin
               r = '{re: '0, im: '0, status: lgf_pkg::ST_EMPTY};
            end else begin
               for (int n = 0; n < pred_count; n++) begin
                  ang = rad_to_turns(longint'(kx) * longint'(pred_x[n]))
                      + rad_to_turns(longint'(ky) * longint'(pred_y[n]))
                      + rad_to_turns(longint'(kz) * longint'(pred_z[n]));
                  rotate_turns(ang, c, s);
                  sum_re += c;
                  sum_im -= s;
               end
               r.re = 32'(clip32(sum_re / pred_count));
               r.im = 32'(clip32(sum_im / pred_count));
               r.status = pred_dropped ? lgf_pkg::ST_DROPPED : lgf_pkg::ST_OK;
            end
            gamma_queue.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] cmd, input logic [31:0] vx,
                            input logic [31:0] vy, input logic [31:0] vz);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {vz, vy, vx};
      req_tuser  <= cmd;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_gamma(cmd, vx, vy, vz);
      items_sent++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
         2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
         default: return 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
      endcase
   endfunction

   // Receiver: random stalls per item, or a long hold-off when requested.
   initial begin
      int wait_n;
      @(negedge reset);
      forever begin
         wait_n = no_idle ? 0 : $urandom_range(0, 12);
         if (rsp_hold > 0) begin
            wait_n = rsp_hold;
            rsp_hold = 0;
         end
         if (wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Result checker.
   always @(posedge clock) begin
      gamma_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         gammas_seen++;
         if (gamma_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: re=%h im=%h status=%0d",
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
         end else begin
            want = gamma_queue.pop_front();
            if (rsp_tdata[31:0] !== want.re || rsp_tdata[63:32] !== want.im ||
                rsp_tuser !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected re=%h im=%h status=%0d, ",
                            "got re=%h im=%h status=%0d"},
                           want.re, want.im, want.status,
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(lgf_pkg::CMD_QUERY, 32'h0001_0000, 32'h0, 32'h0);
      send_item(lgf_pkg::CMD_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_item(lgf_pkg::CMD_APPEND, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000);
      send_item(lgf_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0);
      send_item(lgf_pkg::CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(lgf_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(lgf_pkg::CMD_QUERY, 32'h0006_487F, 32'h0003_243F, 32'h0);
      send_item(lgf_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
      send_item(lgf_pkg::CMD_QUERY, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_item(lgf_pkg::CMD_APPEND, 32'h0001_0000, 32'h0, 32'h0);
      send_item(lgf_pkg::CMD_QUERY, 32'h0001_921F, 32'h0, 32'h0);
      send_item(lgf_pkg::CMD_QUERY, 32'h0003_243F, 32'h0, 32'h0);
   endtask

   // Fills the list past its depth so that appends are dropped, queries it, then clears it and queries again.
   task automatic test_overflow();
      send_item(lgf_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < NBR_DEPTH + 3; i++)
         send_item(lgf_pkg::CMD_APPEND, rand_coord(), rand_coord(), rand_coord());
      send_item(lgf_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
      send_item(lgf_pkg::CMD_APPEND, rand_coord(), rand_coord(), rand_coord());
      send_item(lgf_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
      send_item(lgf_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
      send_item(lgf_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
   endtask

   // Long receiver hold-off while queries keep arriving on a small list.
   task automatic test_backpressure();
      send_item(lgf_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
      send_item(lgf_pkg::CMD_APPEND, rand_coord(), rand_coord(), rand_coord());
      send_item(lgf_pkg::CMD_APPEND, rand_coord(), rand_coord(), rand_coord());
      rsp_hold = 3000;
      for (int i = 0; i < 12; i++)
         send_item(lgf_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic test_random(input int n_items);
      int start, len, n_q;
      start = items_sent;
      while (items_sent - start < n_items) begin
         no_idle = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) == 0) begin
            // Noise: stray commands of any kind.
            repeat ($urandom_range(1, 4))
               send_item(2'($urandom()), rand_coord(), rand_coord(), rand_coord());
         end else begin
            if ($urandom_range(0, 3) != 0)
               send_item(lgf_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
            len = ($urandom_range(0, 40) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
            repeat (len)
               send_item(lgf_pkg::CMD_APPEND, rand_coord(), rand_coord(), rand_coord());
            n_q = $urandom_range(1, 4);
            repeat (n_q)
               send_item(lgf_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
         end
      end
      no_idle = 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random(1500);
      req_tvalid <= 1'b0;
      while (gamma_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d items (clears, appends, queries, unused commands), checked %0d gammas,",
               items_sent, gammas_seen);
      $display("including empty and overflowed lists and a long output hold-off.");
      if (mismatches == 0 && gamma_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/lgf_pkg.sv
rtl/lgf_ctrl.sv
rtl/lgf_dp.sv
rtl/lattice_gamma_factor.sv
test/tb_lattice_gamma_factor.sv
